### sv/cfc_pkg.sv
// Package with the item types, register indexes and sequencer states of the circle fit checker.
package cfc_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned RADIUS_W = 25;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_POINTS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOL_FLOOR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOL_PERMILLE = 2'd2;

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_MEAN = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RADIUS_W-1:0] mean_radius;
    logic is_circle;
    logic overflow;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FEW,
    S_DSET,
    S_DWAIT,
    S_LOAD,
    S_DIFF,
    S_SQUARE,
    S_SQGO,
    S_SQWAIT,
    S_CHECK,
    S_JUDGE,
    S_DONE
  } state_t;

endpackage

### sv/circle_fit_checker.sv
// Top level of the circle fit checker: point store, running sums and the fit sequencer.
//
// Points enter on point when start is high and busy is low, one item per cycle
// while the list is loading. Each point goes into the point memory and into the
// running coordinate sums; points beyond MAX_POINTS are dropped and flag overflow.
// The point marked last_point makes busy rise and starts the fit pass. A list with
// fewer than min_points points skips the fit and gives its result through S_FEW.
// Otherwise the shared divider forms the three centroid coordinates one after the
// other. Every stored point then goes through a memory read, the differences, the
// squares and the bit-serial square root. The mean radius takes one more divide,
// and then the tolerance check follows. The result sits on result for exactly one
// cycle with done high, and busy falls as the state leaves S_DONE for S_IDLE; the
// receiver cannot stall the result.
// Configuration writes on cfg_we, cfg_index and cfg_data belong between lists.
// Reset clears the list and loads the default register values; the memory needs
// no clearing since only entries of the current list are read.
module circle_fit_checker #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  cfc_pkg::point_t                     point,
  output logic                                done,
  output cfc_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [cfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 24 + AW;
  localparam int unsigned DW = 26 + AW;
  localparam int unsigned MW = (CW > 9) ? CW : 9;
  localparam int unsigned RSW = 25 + AW;

  cfc_pkg::state_t state, state_next;

  logic [8:0]  min_points;
  logic [15:0] tol_floor;
  logic [9:0]  tol_permille;

  logic [CW-1:0]        count;
  logic                 ovf;
  logic signed [SW-1:0] sum_x, sum_y, sum_z;

  logic [71:0] mem [MAX_POINTS];
  logic [71:0] rdata;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] n_after;
  logic          enough;

  logic [1:0]           sel;
  logic [CW-1:0]        pidx;
  logic signed [23:0]   cx, cy, cz;
  logic signed [24:0]   dx, dy, dz;
  logic [48:0]          sqx, sqy, sqz;
  logic [24:0]          rmin, rmax;
  logic [RSW-1:0]       rsum;
  logic [24:0]          mean;
  logic [34:0]          prod_a, prod_b;
  logic [24:0]          spread;

  logic                 div_start, div_done;
  logic [DW-1:0]        div_dividend, div_quot;
  logic signed [SW-1:0] div_sum;
  logic                 div_neg;
  logic [SW-1:0]        div_mag;
  logic [23:0]          cq;
  logic                 sq_start, sq_done;
  logic [49:0]          sq_value;
  logic [24:0]          sq_root;

  assign busy = state != cfc_pkg::S_IDLE;
  assign accept = start && !busy;
  assign has_room = count < CW'(MAX_POINTS);
  assign n_after = has_room ? count + 1'b1 : count;
  assign enough = (MW'(n_after) >= MW'(min_points)) && (n_after != '0);
  assign done = state == cfc_pkg::S_DONE;

  always_comb begin
    unique case (sel)
      cfc_pkg::SEL_X: div_sum = sum_x;
      cfc_pkg::SEL_Y: div_sum = sum_y;
      default: div_sum = sum_z;
    endcase
  end

  assign div_neg = div_sum[SW-1];
  assign div_mag = div_neg ? SW'(-div_sum) : SW'(div_sum);
  assign div_dividend = (sel == cfc_pkg::SEL_MEAN)
                        ? DW'(rsum) + DW'(count >> 1)
                        : DW'(div_mag) + DW'(count >> 1);
  assign cq = div_neg ? 24'(-div_quot[23:0]) : div_quot[23:0];
  assign div_start = state == cfc_pkg::S_DSET;
  assign sq_start = state == cfc_pkg::S_SQGO;
  assign sq_value = 50'(sqx) + 50'(sqy) + 50'(sqz);
  assign spread = rmax - rmin;

  cfc_div #(.DW(DW), .NW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  cfc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cfc_pkg::S_IDLE: begin
        if (accept && point.last_point) begin
          state_next = enough ? cfc_pkg::S_DSET : cfc_pkg::S_FEW;
        end
      end
      cfc_pkg::S_FEW: state_next = cfc_pkg::S_DONE;
      cfc_pkg::S_DSET: state_next = cfc_pkg::S_DWAIT;
      cfc_pkg::S_DWAIT: begin
        if (div_done) begin
          priority if (sel == cfc_pkg::SEL_MEAN) begin
            state_next = cfc_pkg::S_CHECK;
          end else if (sel == cfc_pkg::SEL_Z) begin
            state_next = cfc_pkg::S_LOAD;
          end else begin
            state_next = cfc_pkg::S_DSET;
          end
        end
      end
      cfc_pkg::S_LOAD: state_next = cfc_pkg::S_DIFF;
      cfc_pkg::S_DIFF: state_next = cfc_pkg::S_SQUARE;
      cfc_pkg::S_SQUARE: state_next = cfc_pkg::S_SQGO;
      cfc_pkg::S_SQGO: state_next = cfc_pkg::S_SQWAIT;
      cfc_pkg::S_SQWAIT: begin
        if (sq_done) begin
          state_next = (pidx + 1'b1 == count) ? cfc_pkg::S_DSET : cfc_pkg::S_LOAD;
        end
      end
      cfc_pkg::S_CHECK: state_next = cfc_pkg::S_JUDGE;
      cfc_pkg::S_JUDGE: state_next = cfc_pkg::S_DONE;
      cfc_pkg::S_DONE: state_next = cfc_pkg::S_IDLE;
      default: state_next = cfc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_points <= 9'd6;
      tol_floor <= 16'd50;
      tol_permille <= 10'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfc_pkg::REG_MIN_POINTS: min_points <= cfg_data[8:0];
        cfc_pkg::REG_TOL_FLOOR: tol_floor <= cfg_data;
        cfc_pkg::REG_TOL_PERMILLE: tol_permille <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf <= 1'b0;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      sel <= cfc_pkg::SEL_X;
      pidx <= '0;
    end else begin
      if (accept) begin
        if (has_room) begin
          count <= n_after;
          sum_x <= sum_x + {{(SW-24){point.point_x[23]}}, point.point_x};
          sum_y <= sum_y + {{(SW-24){point.point_y[23]}}, point.point_y};
          sum_z <= sum_z + {{(SW-24){point.point_z[23]}}, point.point_z};
        end else begin
          ovf <= 1'b1;
        end
        sel <= cfc_pkg::SEL_X;
        pidx <= '0;
      end
      if (state == cfc_pkg::S_DWAIT && div_done && sel != cfc_pkg::SEL_MEAN) begin
        sel <= sel + 1'b1;
      end
      if (state == cfc_pkg::S_SQWAIT && sq_done) begin
        pidx <= pidx + 1'b1;
        if (pidx + 1'b1 == count) begin
          sel <= cfc_pkg::SEL_MEAN;
        end
      end
      if (state == cfc_pkg::S_DONE) begin
        count <= '0;
        ovf <= 1'b0;
        sum_x <= '0;
        sum_y <= '0;
        sum_z <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      mem[count[AW-1:0]] <= {point.point_x, point.point_y, point.point_z};
    end
    if (state == cfc_pkg::S_LOAD) begin
      rdata <= mem[pidx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rmin <= '1;
      rmax <= '0;
      rsum <= '0;
    end
    if (state == cfc_pkg::S_DWAIT && div_done) begin
      unique case (sel)
        cfc_pkg::SEL_X: cx <= cq;
        cfc_pkg::SEL_Y: cy <= cq;
        cfc_pkg::SEL_Z: cz <= cq;
        default: mean <= div_quot[24:0];
      endcase
    end
    if (state == cfc_pkg::S_DIFF) begin
      dx <= 25'(signed'(rdata[71:48])) - 25'(cx);
      dy <= 25'(signed'(rdata[47:24])) - 25'(cy);
      dz <= 25'(signed'(rdata[23:0])) - 25'(cz);
    end
    if (state == cfc_pkg::S_SQUARE) begin
      sqx <= 49'(dx * dx);
      sqy <= 49'(dy * dy);
      sqz <= 49'(dz * dz);
    end
    if (state == cfc_pkg::S_SQWAIT && sq_done) begin
      if (sq_root < rmin) begin
        rmin <= sq_root;
      end
      if (sq_root > rmax) begin
        rmax <= sq_root;
      end
      rsum <= rsum + RSW'(sq_root);
    end
    if (state == cfc_pkg::S_CHECK) begin
      prod_a <= 35'(spread) * 35'(1000);
      prod_b <= 35'(mean) * 35'(tol_permille);
    end
    if (state == cfc_pkg::S_FEW) begin
      result.center_x <= '0;
      result.center_y <= '0;
      result.center_z <= '0;
      result.mean_radius <= '0;
      result.is_circle <= 1'b0;
      result.overflow <= ovf;
    end
    if (state == cfc_pkg::S_JUDGE) begin
      result.center_x <= cx;
      result.center_y <= cy;
      result.center_z <= cz;
      result.mean_radius <= mean;
      result.is_circle <= (mean != '0) && !ovf &&
                          ((spread <= 25'(tol_floor)) || (prod_a <= prod_b));
      result.overflow <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && point.last_point) |=> busy)
    else $error("last point did not start the fit pass");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result delivered while idle");
  a_circle_ovf: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_circle) |-> !result.overflow)
    else $error("circle reported on an overflowed list");
`endif

endmodule

### sv/cfc_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module cfc_div #(
  parameter int unsigned DW = 34,
  parameter int unsigned NW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [NW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [NW:0]     sh;
  logic            fits;

  assign sh = {rem, quotient[DW-1]};
  assign fits = sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
    end else if (run) begin
      if (fits) begin
        rem <= NW'(sh - {1'b0, divisor});
      end else begin
        rem <= sh[NW-1:0];
      end
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

### sv/cfc_isqrt.sv
// Digit-by-digit floor square root of a 50-bit value, one root bit per cycle.
module cfc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] value,
  output logic        done,
  output logic [24:0] root
);

  logic [49:0] v;
  logic [26:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [28:0] sh;
  logic [28:0] trial;
  logic        fits;

  assign sh = {rem, v[49:48]};
  assign trial = {2'b00, root, 2'b01};
  assign fits = sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd25;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      rem <= '0;
      root <= '0;
    end else if (run) begin
      v <= {v[47:0], 2'b00};
      if (fits) begin
        rem <= 27'(sh - trial);
      end else begin
        rem <= sh[26:0];
      end
      root <= {root[23:0], fits};
    end
  end

endmodule
